// ===== hw/rtl/frbk_pkg.sv =====
`timescale 1ns / 1ps

package frbk_pkg;

    // default sizes of the queue
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 56;

    // fixed port widths
    localparam int CMD_W    = 2;
    localparam int PLATE_W  = 56;
    localparam int OUT7_W   = 7;
    localparam int STATUS_W = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

endpackage

// ===== hw/rtl/frbk_cell.sv =====
`timescale 1ns / 1ps

module frbk_cell #(
    parameter int KEY_BITS = frbk_pkg::KEY_BITS_DEF,
    parameter int POS_W    = 6,
    parameter int POS      = 0
) (
    input  logic                 clk,
    input  frbk_pkg::cell_op_t   op,
    input  logic [POS_W-1:0]     idx,
    input  logic [KEY_BITS-1:0]  din,
    input  logic [KEY_BITS-1:0]  next_key,
    input  logic [KEY_BITS-1:0]  front_key,
    output logic [KEY_BITS-1:0]  key
);
    import frbk_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                here;

    assign here = (idx == POS_W'(POS));

    // load at the tail, shift toward the front, or rotate front to tail
    always_comb
    begin
        key_next = key_reg;
        case (op)
            OP_LOAD:
            begin
                if (here)
                begin
                    key_next = din;
                end
            end
            OP_SHIFT:
            begin
                key_next = next_key;
            end
            OP_ROTATE:
            begin
                key_next = here ? front_key : next_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

// ===== hw/rtl/frbk_ctrl.sv =====
`timescale 1ns / 1ps

module frbk_ctrl #(
    parameter int DEPTH    = frbk_pkg::DEPTH_DEF,
    parameter int KEY_BITS = frbk_pkg::KEY_BITS_DEF,
    parameter int POS_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [frbk_pkg::CMD_W-1:0]    cmd,
    input  logic [KEY_BITS-1:0]           key_in,
    input  logic [KEY_BITS-1:0]           front_key,
    output frbk_pkg::cell_op_t            op,
    output logic [POS_W-1:0]              idx,
    output logic                          busy,
    output logic                          done,
    output logic [KEY_BITS-1:0]           res_key,
    output logic [frbk_pkg::OUT7_W-1:0]   res_moved,
    output logic [frbk_pkg::STATUS_W-1:0] res_status,
    output logic [frbk_pkg::OUT7_W-1:0]   res_occ
);
    import frbk_pkg::*;

    localparam int MV_W = $clog2(DEPTH + 2);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                match0_reg, match0_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                done_reg, done_next;
    logic [KEY_BITS-1:0] rkey_reg, rkey_next;
    logic [OUT7_W-1:0]   rmoved_reg, rmoved_next;
    status_t             rstat_reg, rstat_next;
    logic [OUT7_W-1:0]   rocc_reg, rocc_next;

    logic                accept;
    logic                front_hit;
    logic [CNT_W-1:0]    cnt_m1;
    logic [MV_W-1:0]     moves_k;
    logic [MV_W-1:0]     moves_n;

    assign accept    = start && (state_reg == S_IDLE);
    assign front_hit = (front_key == key_reg);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign moves_k   = MV_W'(step_reg) + MV_W'(1);
    assign moves_n   = MV_W'(count_reg) + MV_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_REMOVE) && (count_reg != '0))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (step_reg != '0)
                begin
                    if (((step_reg < count_reg) && front_hit) || (step_reg == count_reg))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // cell commands and result values
    always_comb
    begin
        op          = OP_HOLD;
        idx         = count_reg[POS_W-1:0];
        count_next  = count_reg;
        step_next   = step_reg;
        match0_next = match0_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        rkey_next   = rkey_reg;
        rmoved_next = rmoved_reg;
        rstat_next  = rstat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    rkey_next   = '0;
                    rmoved_next = '0;
                    rstat_next  = STAT_OK;
                    case (cmd)
                        CMD_ENQ:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                rstat_next = STAT_FULL;
                            end
                            else
                            begin
                                op         = OP_LOAD;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                op         = OP_SHIFT;
                                rkey_next  = front_key;
                                count_next = cnt_m1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = STAT_EMPTY;
                            end
                            else
                            begin
                                done_next = 1'b0;
                                key_next  = key_in;
                                step_next = '0;
                            end
                        end
                        default:
                        begin
                            rstat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // cell 0 holds the entry at original position step_reg
                idx = cnt_m1[POS_W-1:0];
                if (step_reg == '0)
                begin
                    match0_next = front_hit;
                    op          = OP_ROTATE;
                    step_next   = step_reg + CNT_W'(1);
                end
                else if ((step_reg < count_reg) && front_hit)
                begin
                    op          = OP_SHIFT;
                    count_next  = cnt_m1;
                    done_next   = 1'b1;
                    rkey_next   = '0;
                    rmoved_next = OUT7_W'(moves_k);
                    rstat_next  = STAT_OK;
                end
                else if (step_reg == count_reg)
                begin
                    done_next = 1'b1;
                    rkey_next = '0;
                    if (match0_reg)
                    begin
                        op          = OP_SHIFT;
                        count_next  = cnt_m1;
                        rmoved_next = OUT7_W'(moves_n);
                        rstat_next  = STAT_OK;
                    end
                    else
                    begin
                        rmoved_next = OUT7_W'(count_reg);
                        rstat_next  = STAT_NOT_FOUND;
                    end
                end
                else
                begin
                    op        = OP_ROTATE;
                    step_next = step_reg + CNT_W'(1);
                end
            end
            default:
            begin
                op = OP_HOLD;
            end
        endcase
        rocc_next = done_next ? OUT7_W'(count_next) : rocc_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        match0_reg <= match0_next;
        key_reg    <= key_next;
        rkey_reg   <= rkey_next;
        rmoved_reg <= rmoved_next;
        rstat_reg  <= rstat_next;
        rocc_reg   <= rocc_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign res_key    = rkey_reg;
    assign res_moved  = rmoved_reg;
    assign res_status = rstat_reg;
    assign res_occ    = rocc_reg;

endmodule

// ===== hw/rtl/fifo_remove_by_key_rotate.sv =====
// enqueue, pop, the unused command and a remove on an empty queue give their result
// in the cycle after the transaction is accepted; busy stays low, one per cycle
// remove with n>0 entries: the scan runs the queue through cell 0, ending when a
// target at k>0 reaches it, or after all n for a target at 0 or absent; busy is
// high during the scan, low with the result; a result shows for one cycle, no stall
// reset: control and count clear at once, queue empty; cell keys are not reset
`timescale 1ns / 1ps

module fifo_remove_by_key_rotate #(
    parameter int DEPTH    = frbk_pkg::DEPTH_DEF,
    parameter int KEY_BITS = frbk_pkg::KEY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [frbk_pkg::CMD_W-1:0]    cmd,
    input  logic [frbk_pkg::PLATE_W-1:0]  plate,
    output logic                          busy,
    output logic                          done,
    output logic [frbk_pkg::PLATE_W-1:0]  plate_out,
    output logic [frbk_pkg::OUT7_W-1:0]   moved,
    output logic [frbk_pkg::STATUS_W-1:0] status,
    output logic [frbk_pkg::OUT7_W-1:0]   occupancy
);
    import frbk_pkg::*;

    localparam int POS_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [63:0]         plate_wide;
    logic [63:0]         res_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [KEY_BITS-1:0] res_key;
    logic [KEY_BITS-1:0] key_q [DEPTH];
    cell_op_t            op;
    logic [POS_W-1:0]    idx;

    // key taken from the low bits of plate
    assign plate_wide = 64'(plate);
    assign key_in     = plate_wide[KEY_BITS-1:0];

    // sequencer
    frbk_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .POS_W    (POS_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .key_in     (key_in),
        .front_key  (key_q[0]),
        .op         (op),
        .idx        (idx),
        .busy       (busy),
        .done       (done),
        .res_key    (res_key),
        .res_moved  (moved),
        .res_status (status),
        .res_occ    (occupancy)
    );

    // row of cells, cell 0 is the front of the queue
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] nxt;
        if (i == DEPTH - 1)
        begin : g_last
            assign nxt = key_q[i];
        end
        else
        begin : g_mid
            assign nxt = key_q[i+1];
        end
        frbk_cell #(
            .KEY_BITS (KEY_BITS),
            .POS_W    (POS_W),
            .POS      (i)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .idx       (idx),
            .din       (key_in),
            .next_key  (nxt),
            .front_key (key_q[0]),
            .key       (key_q[i])
        );
    end

    // popped key onto the fixed-width output
    assign res_wide  = 64'(res_key);
    assign plate_out = res_wide[PLATE_W-1:0];

`ifndef SYNTHESIS
    // no result while a remove is still scanning
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // commands other than remove answer on the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != CMD_REMOVE)) |=> done)
        else $error("missing result for single-cycle command");

    // a failed search moves every entry and leaves the count alone
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_NOT_FOUND)) |-> (moved == occupancy))
        else $error("not-found move count differs from occupancy");

    // a dropped enqueue only happens on a full queue
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_FULL)) |-> (occupancy == OUT7_W'(DEPTH)))
        else $error("full status with queue not full");
`endif

endmodule

// ===== test/tb_fifo_remove_by_key_rotate.sv =====
`timescale 1ns / 1ps

module tb_fifo_remove_by_key_rotate;

    import frbk_pkg::*;

    localparam int QDEPTH     = DEPTH_DEF;
    localparam int RAND_ITEMS = 2000;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int DRAIN_WAIT = QDEPTH + 20;

    // one expected result
    typedef struct {
        logic [PLATE_W-1:0] plate;
        logic [OUT7_W-1:0]  moved;
        status_t            status;
        logic [OUT7_W-1:0]  occupancy;
    } outcome_t;

    // shadow queue of plates plus the results still owed by the block
    class plate_queue_tracker;
        logic [PLATE_W-1:0] held_plates[$];
        outcome_t           pending_results[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // rotate-and-remove queue behavior for one command
        function outcome_t apply_command(cmd_t op, logic [PLATE_W-1:0] key);
            outcome_t           r;
            logic [PLATE_W-1:0] rest[$];
            int                 n;
            int                 k;
            r.plate  = '0;
            r.moved  = '0;
            r.status = STAT_OK;
            n = held_plates.size();
            k = -1;
            case (op)
                CMD_ENQ:
                begin
                    if (n >= QDEPTH)
                        r.status = STAT_FULL;
                    else
                        held_plates.push_back(key);
                end
                CMD_POP:
                begin
                    if (n == 0)
                        r.status = STAT_EMPTY;
                    else
                        r.plate = held_plates.pop_front();
                end
                CMD_REMOVE:
                begin
                    if (n == 0)
                        r.status = STAT_EMPTY;
                    else
                    begin
                        // a match behind the front wins over the front itself
                        for (int i = 1; i < n; i++)
                        begin
                            if (held_plates[i] == key)
                            begin
                                k = i;
                                break;
                            end
                        end
                        if (k < 0 && held_plates[0] == key)
                            k = 0;
                        if (k < 0)
                        begin
                            r.moved  = OUT7_W'(n);
                            r.status = STAT_NOT_FOUND;
                        end
                        else if (k == 0)
                        begin
                            r.moved = OUT7_W'(n + 1);
                            void'(held_plates.pop_front());
                        end
                        else
                        begin
                            // entries after the target, then those before it
                            r.moved = OUT7_W'(k + 1);
                            for (int i = k + 1; i < n; i++)
                                rest.push_back(held_plates[i]);
                            for (int i = 0; i < k; i++)
                                rest.push_back(held_plates[i]);
                            held_plates = rest;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.occupancy = OUT7_W'(held_plates.size());
            return r;
        endfunction

        task note_command(cmd_t op, logic [PLATE_W-1:0] key);
            pending_results.push_back(apply_command(op, key));
        endtask

        task check_result(logic [PLATE_W-1:0] p, logic [OUT7_W-1:0] mv,
                          logic [STATUS_W-1:0] st, logic [OUT7_W-1:0] occ);
            outcome_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding at %0t", $realtime));
                return;
            end
            e = pending_results.pop_front();
            if (p !== e.plate)
                report($sformatf("plate_out %h, want %h at %0t", p, e.plate, $realtime));
            if (mv !== e.moved)
                report($sformatf("moved %0d, want %0d at %0t", mv, e.moved, $realtime));
            if (st !== e.status)
                report($sformatf("status %0d, want %0d at %0t", st, e.status, $realtime));
            if (occ !== e.occupancy)
                report($sformatf("occupancy %0d, want %0d at %0t", occ, e.occupancy,
                                 $realtime));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [CMD_W-1:0]    cmd;
    logic [PLATE_W-1:0]  plate;
    logic                busy;
    logic                done;
    logic [PLATE_W-1:0]  plate_out;
    logic [OUT7_W-1:0]   moved;
    logic [STATUS_W-1:0] status;
    logic [OUT7_W-1:0]   occupancy;

    plate_queue_tracker tracker = new();
    int unsigned        cycles = 0;

    fifo_remove_by_key_rotate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .plate     (plate),
        .busy      (busy),
        .done      (done),
        .plate_out (plate_out),
        .moved     (moved),
        .status    (status),
        .occupancy (occupancy)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // check results, then log the transaction accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tracker.check_result(plate_out, moved, status, occupancy);
            if (start && !busy)
                tracker.note_command(cmd_t'(cmd), plate);
        end
    end

    function automatic logic [PLATE_W-1:0] any_plate();
        return PLATE_W'({$urandom, $urandom});
    endfunction

    // present one transaction and hold it until the block takes it
    task automatic issue_command(cmd_t op, logic [PLATE_W-1:0] key);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= op;
        plate <= key;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic hold_off(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // pick a plate that is held now, biased toward the front entry
    function automatic logic [PLATE_W-1:0] held_plate();
        int n;
        n = tracker.held_plates.size();
        if (n == 0)
            return any_plate();
        if ($urandom_range(0, 4) == 0)
            return tracker.held_plates[0];
        return tracker.held_plates[$urandom_range(0, n - 1)];
    endfunction

    task automatic random_phase();
        bit filling;
        int n;
        int roll;
        filling = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            n = tracker.held_plates.size();
            if (n == QDEPTH && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            if (n == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (filling)
            begin
                if (roll < 65)
                    issue_command(CMD_ENQ, (n > 0 && $urandom_range(0, 6) == 0) ?
                                           held_plate() : any_plate());
                else if (roll < 85)
                    issue_command(CMD_REMOVE, held_plate());
                else if (roll < 90)
                    issue_command(CMD_REMOVE, any_plate());
                else if (roll < 97)
                    issue_command(CMD_POP, any_plate());
                else
                    issue_command(CMD_NONE, any_plate());
            end
            else
            begin
                if (roll < 20)
                    issue_command(CMD_ENQ, any_plate());
                else if (roll < 50)
                    issue_command(CMD_REMOVE, held_plate());
                else if (roll < 55)
                    issue_command(CMD_REMOVE, any_plate());
                else if (roll < 95)
                    issue_command(CMD_POP, any_plate());
                else
                    issue_command(CMD_NONE, any_plate());
            end
            // random sender gaps, none in the middle stretch
            if ((i < 800 || i >= 1200) && $urandom_range(0, 99) < 9)
                hold_off($urandom_range(1, 8));
        end
    endtask

    // main sequence
    initial
    begin
        logic [PLATE_W-1:0] a;
        logic [PLATE_W-1:0] b;
        int                 wait_cycles;
        start = 1'b0;
        cmd   = CMD_NONE;
        plate = '0;
        rst_n = 1'b0;
        a = any_plate();
        b = any_plate();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, unused command, extremes, rotation cases
        issue_command(CMD_POP, '0);
        issue_command(CMD_REMOVE, '1);
        issue_command(CMD_NONE, '1);
        issue_command(CMD_ENQ, '0);
        issue_command(CMD_ENQ, '1);
        issue_command(CMD_ENQ, a);
        issue_command(CMD_ENQ, b);
        issue_command(CMD_ENQ, a);
        issue_command(CMD_REMOVE, a);
        issue_command(CMD_REMOVE, b);
        issue_command(CMD_ENQ, {(PLATE_W/2){2'b10}});
        issue_command(CMD_ENQ, {(PLATE_W/2){2'b01}});
        issue_command(CMD_REMOVE, {(PLATE_W/2){2'b11}});
        issue_command(CMD_REMOVE, tracker.held_plates[0]);
        issue_command(CMD_NONE, '0);
        issue_command(CMD_POP, '0);
        issue_command(CMD_REMOVE, tracker.held_plates[tracker.held_plates.size() - 1]);
        issue_command(CMD_POP, '1);
        issue_command(CMD_POP, '0);
        issue_command(CMD_POP, '0);
        issue_command(CMD_REMOVE, '0);

        random_phase();
        hold_off(1);

        // wait for every outstanding result, then let the block settle
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        wait_cycles = DRAIN_WAIT;
        repeat (wait_cycles) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
